// File: src/o2msg_pkg.sv
// Package for the order-2 Markov symbol generator: opcodes, status codes,
// register indexes, controller states and the controller/datapath command bundles.
// No dependencies.
package o2msg_pkg;

  localparam int OP_W       = 3;
  localparam int SYM_IN_W   = 5;
  localparam int RAND_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int ALPHA_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int NCMP_W     = 7;
  localparam int PHASE_W    = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 6'd32;

  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_DONE   = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_SET_CTX  = 3'd1,
    OP_LEARN    = 3'd2,
    OP_FINALIZE = 3'd3,
    OP_GENERATE = 3'd4,
    OP_RESTART  = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_DEAD  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA       = 2'd0,
    CFG_INIT_FIRST  = 2'd1,
    CFG_INIT_SECOND = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_LEARN_RD,
    S_LEARN_WR,
    S_FIN_RD,
    S_FIN_WR,
    S_TOT_RD,
    S_TOT_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic clr_step;
    logic learn_rd;
    logic learn_wr;
    logic fin_rd;
    logic fin_wr;
    logic tot_rd;
    logic scan_rd;
    logic scan_dec;
    logic gen_dead;
    logic gen_commit;
    logic commit_hit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            learn_ok;
    logic            gen_go;
    logic            clr_last;
    logic            fin_last;
    logic            tot_zero;
    logic            hit;
    logic            scan_zero;
    logic            scan_one;
    logic            out_free;
  } dp_stat_t;

endpackage

// File: src/o2msg_dp.sv
// Datapath of the order-2 Markov symbol generator: configuration, contexts,
// count table memory, sweep counters and the result register. Uses o2msg_pkg.
module o2msg_dp import o2msg_pkg::*; #(
  parameter int MAX_SYMBOLS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [SYM_IN_W-1:0]   in_symbol_a,
  input  logic [SYM_IN_W-1:0]   in_symbol_b,
  input  logic [RAND_W-1:0]     in_random_value,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SYM_IN_W-1:0]   out_symbol_out,
  output logic [STATUS_W-1:0]   out_status
);

  localparam int SYM_W  = $clog2(MAX_SYMBOLS);
  localparam int CTX_W  = (SYM_W > SYM_IN_W) ? SYM_W : SYM_IN_W;
  localparam int ADDR_W = 3 * SYM_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CMP_W  = (COUNT_BITS > RAND_W) ? COUNT_BITS : RAND_W;
  localparam logic [NCMP_W-1:0] MAX_N = NCMP_W'(MAX_SYMBOLS);

  logic [ALPHA_W-1:0]    alpha_r;
  logic [SYM_IN_W-1:0]   init_first_r;
  logic [SYM_IN_W-1:0]   init_second_r;
  logic [OP_W-1:0]       op_r;
  logic [SYM_IN_W-1:0]   a_r;
  logic [SYM_IN_W-1:0]   b_r;
  logic [RAND_W-1:0]     rnd_r;
  logic [CTX_W-1:0]      learn_older_r;
  logic [CTX_W-1:0]      learn_newer_r;
  logic [CTX_W-1:0]      gen_older_r;
  logic [CTX_W-1:0]      gen_newer_r;
  logic [PHASE_W-1:0]    seed_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic [SYM_W-1:0]      fin_i_r;
  logic [SYM_W-1:0]      fin_j_r;
  logic [SYM_W-1:0]      fin_k_r;
  logic [COUNT_BITS-1:0] acc_r;
  logic [SYM_W-1:0]      scan_j_r;
  logic [CTX_W-1:0]      res_sym_r;
  status_t               res_status_r;
  logic                  out_valid_r;
  logic [SYM_IN_W-1:0]   out_sym_r;
  status_t               out_status_r;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata_r;

  logic [NCMP_W-1:0]     n_c;
  logic [SYM_W-1:0]      n_m1;
  logic [CTX_W-1:0]      a_ctx;
  logic [CTX_W-1:0]      b_ctx;
  logic                  a_ok;
  logic                  b_ok;
  logic                  learn_ok;
  logic                  gen_ok;
  logic                  seed_pending;
  logic                  k_last;
  logic                  j_last;
  logic                  i_last;
  logic [COUNT_BITS-1:0] fin_sum;
  logic [ADDR_W-1:0]     learn_addr;
  logic [ADDR_W-1:0]     fin_addr;
  logic [ADDR_W-1:0]     tot_addr;
  logic [ADDR_W-1:0]     scan_addr;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic                  we;
  logic [CTX_W-1:0]      commit_sym;
  logic [CTX_W-1:0]      dec_sym;
  status_t               dec_status;

  // Active alphabet size: zero acts as one, anything above the table size is clamped.
  always_comb begin
    if (alpha_r == '0) begin
      n_c = NCMP_W'(1);
    end else if (NCMP_W'(alpha_r) > MAX_N) begin
      n_c = MAX_N;
    end else begin
      n_c = NCMP_W'(alpha_r);
    end
  end

  assign n_m1         = SYM_W'(n_c - NCMP_W'(1));
  assign a_ctx        = CTX_W'(a_r);
  assign b_ctx        = CTX_W'(b_r);
  assign a_ok         = NCMP_W'(a_r) < n_c;
  assign b_ok         = NCMP_W'(b_r) < n_c;
  assign learn_ok     = a_ok && (NCMP_W'(learn_older_r) < n_c) &&
                        (NCMP_W'(learn_newer_r) < n_c);
  assign gen_ok       = (NCMP_W'(gen_older_r) < n_c) && (NCMP_W'(gen_newer_r) < n_c);
  assign seed_pending = (seed_r == PHASE_FIRST) || (seed_r == PHASE_SECOND);

  assign k_last  = fin_k_r == n_m1;
  assign j_last  = fin_j_r == n_m1;
  assign i_last  = fin_i_r == n_m1;
  assign fin_sum = acc_r + rdata_r;

  assign learn_addr = {learn_older_r[SYM_W-1:0], learn_newer_r[SYM_W-1:0],
                       a_ctx[SYM_W-1:0]};
  assign fin_addr   = {fin_i_r, fin_j_r, fin_k_r};
  assign tot_addr   = {gen_older_r[SYM_W-1:0], gen_newer_r[SYM_W-1:0], n_m1};
  assign scan_addr  = {gen_older_r[SYM_W-1:0], gen_newer_r[SYM_W-1:0],
                       SYM_W'(scan_j_r - SYM_W'(1))};
  assign commit_sym = cmd.commit_hit ? CTX_W'(scan_j_r) : '0;

  always_comb begin
    dec_sym    = '0;
    dec_status = STAT_OK;
    case (op_r)
      OP_SET_CTX: begin
        if (!(a_ok && b_ok)) begin
          dec_status = STAT_RANGE;
        end
      end
      OP_LEARN: begin
        if (!learn_ok) begin
          dec_status = STAT_RANGE;
        end
      end
      OP_GENERATE: begin
        if (seed_r == PHASE_FIRST) begin
          dec_sym = gen_older_r;
        end else if (seed_r == PHASE_SECOND) begin
          dec_sym = gen_newer_r;
        end else if (!gen_ok) begin
          dec_status = STAT_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    raddr = clr_addr_r;
    priority if (cmd.learn_rd) begin
      raddr = learn_addr;
    end else if (cmd.fin_rd) begin
      raddr = fin_addr;
    end else if (cmd.tot_rd) begin
      raddr = tot_addr;
    end else if (cmd.scan_rd) begin
      raddr = scan_addr;
    end else begin
      raddr = clr_addr_r;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_r;
    wdata = '0;
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.learn_wr) begin
      we    = 1'b1;
      waddr = learn_addr;
      wdata = rdata_r + COUNT_BITS'(1);
    end else if (cmd.fin_wr && (fin_k_r != '0)) begin
      we    = 1'b1;
      waddr = fin_addr;
      wdata = fin_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Configuration, contexts, seed phase, clear pointer and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r       <= ALPHA_RESET;
      init_first_r  <= '0;
      init_second_r <= '0;
      learn_older_r <= '0;
      learn_newer_r <= '0;
      gen_older_r   <= '0;
      gen_newer_r   <= '0;
      seed_r        <= PHASE_FIRST;
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA:       alpha_r       <= cfg_data;
          CFG_INIT_FIRST:  init_first_r  <= cfg_data[SYM_IN_W-1:0];
          CFG_INIT_SECOND: init_second_r <= cfg_data[SYM_IN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cmd.decide) begin
        case (op_r)
          OP_SET_CTX: begin
            if (a_ok && b_ok) begin
              learn_older_r <= a_ctx;
              learn_newer_r <= b_ctx;
            end
          end
          OP_GENERATE: begin
            if (seed_r == PHASE_FIRST) begin
              seed_r <= PHASE_SECOND;
            end else if (seed_r == PHASE_SECOND) begin
              seed_r <= PHASE_DONE;
            end
          end
          OP_RESTART: begin
            gen_older_r <= CTX_W'(init_first_r);
            gen_newer_r <= CTX_W'(init_second_r);
            seed_r      <= PHASE_FIRST;
          end
          default: ;
        endcase
      end
      if (cmd.learn_wr) begin
        learn_older_r <= learn_newer_r;
        learn_newer_r <= a_ctx;
      end
      if (cmd.gen_commit) begin
        gen_older_r <= gen_newer_r;
        gen_newer_r <= commit_sym;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, sweep counters, accumulator and result.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      a_r   <= in_symbol_a;
      b_r   <= in_symbol_b;
      rnd_r <= in_random_value;
    end
    if (cmd.decide) begin
      res_sym_r    <= dec_sym;
      res_status_r <= dec_status;
      fin_i_r      <= '0;
      fin_j_r      <= '0;
      fin_k_r      <= '0;
      scan_j_r     <= n_m1;
    end
    if (cmd.fin_wr) begin
      acc_r <= (fin_k_r == '0) ? rdata_r : fin_sum;
      if (k_last) begin
        fin_k_r <= '0;
        if (j_last) begin
          fin_j_r <= '0;
          fin_i_r <= fin_i_r + SYM_W'(1);
        end else begin
          fin_j_r <= fin_j_r + SYM_W'(1);
        end
      end else begin
        fin_k_r <= fin_k_r + SYM_W'(1);
      end
    end
    if (cmd.scan_dec) begin
      scan_j_r <= scan_j_r - SYM_W'(1);
    end
    if (cmd.gen_dead) begin
      res_status_r <= STAT_DEAD;
    end
    if (cmd.gen_commit) begin
      res_sym_r <= commit_sym;
    end
    if (cmd.load_out) begin
      out_sym_r    <= res_sym_r[SYM_IN_W-1:0];
      out_status_r <= res_status_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.learn_ok  = learn_ok;
  assign stat.gen_go    = !seed_pending && gen_ok;
  assign stat.clr_last  = &clr_addr_r;
  assign stat.fin_last  = k_last && j_last && i_last;
  assign stat.tot_zero  = rdata_r == '0;
  assign stat.hit       = CMP_W'(rdata_r) <= CMP_W'(rnd_r);
  assign stat.scan_zero = scan_j_r == '0;
  assign stat.scan_one  = scan_j_r == SYM_W'(1);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_symbol_out = out_sym_r;
  assign out_status     = out_status_r;

endmodule

// File: src/o2msg_ctrl.sv
// Controller state machine of the order-2 Markov symbol generator.
// Sequences clear, learn, finalize and generate commands. Uses o2msg_pkg.
module o2msg_ctrl import o2msg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT_CLR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (stat.op)
          OP_CLEAR:    state_nxt = S_CLEAR;
          OP_LEARN:    state_nxt = stat.learn_ok ? S_LEARN_RD : S_RESP;
          OP_FINALIZE: state_nxt = S_FIN_RD;
          OP_GENERATE: state_nxt = stat.gen_go ? S_TOT_RD : S_RESP;
          default:     state_nxt = S_RESP;
        endcase
      end
      S_CLEAR:    if (stat.clr_last) state_nxt = S_RESP;
      S_LEARN_RD: state_nxt = S_LEARN_WR;
      S_LEARN_WR: state_nxt = S_RESP;
      S_FIN_RD:   state_nxt = S_FIN_WR;
      S_FIN_WR:   state_nxt = stat.fin_last ? S_RESP : S_FIN_RD;
      S_TOT_RD:   state_nxt = S_TOT_CHK;
      S_TOT_CHK:  state_nxt = (stat.tot_zero || stat.scan_zero) ? S_RESP : S_SCAN_RD;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = (stat.hit || stat.scan_one) ? S_RESP : S_SCAN_RD;
      S_RESP:     if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_INIT_CLR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_INIT_CLR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE:   cmd.decide   = 1'b1;
      S_CLEAR:    cmd.clr_step = 1'b1;
      S_LEARN_RD: cmd.learn_rd = 1'b1;
      S_LEARN_WR: cmd.learn_wr = 1'b1;
      S_FIN_RD:   cmd.fin_rd   = 1'b1;
      S_FIN_WR:   cmd.fin_wr   = 1'b1;
      S_TOT_RD:   cmd.tot_rd   = 1'b1;
      S_TOT_CHK: begin
        if (stat.tot_zero) begin
          cmd.gen_dead = 1'b1;
        end else if (stat.scan_zero) begin
          cmd.gen_commit = 1'b1;
        end
      end
      S_SCAN_RD:  cmd.scan_rd = 1'b1;
      S_SCAN_CHK: begin
        if (stat.hit) begin
          cmd.gen_commit = 1'b1;
          cmd.commit_hit = 1'b1;
        end else if (stat.scan_one) begin
          cmd.gen_commit = 1'b1;
        end else begin
          cmd.scan_dec = 1'b1;
        end
      end
      S_RESP:     cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: src/order2_markov_symbol_generator_unit.sv
// Top level of the order-2 Markov symbol generator.
// Joins o2msg_ctrl and o2msg_dp; uses o2msg_pkg.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid/in_ready    in_opcode, in_symbol_a, in_symbol_b,
//                                            in_random_value
//   out      out        out_valid/out_ready  out_symbol_out, out_status
//
// One request at a time; n is the active alphabet size, S = 2**ceil(log2(MAX_SYMBOLS)).
// Set context, restart, seed and rejected requests only decide and respond; learn reads and
// writes one table entry; generate scans the row with one table read and compare per scan step.
// Finalize steps over n**3 table entries and clear over S**3, one table entry per step.
// After reset a clearing pass over all S**3 entries (32768 by default) runs before in_ready rises.
// A result waiting on out_ready holds the next request back only in its response state.
module order2_markov_symbol_generator_unit import o2msg_pkg::*; #(
  parameter int MAX_SYMBOLS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [SYM_IN_W-1:0]   in_symbol_a,
  input  logic [SYM_IN_W-1:0]   in_symbol_b,
  input  logic [RAND_W-1:0]     in_random_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SYM_IN_W-1:0]   out_symbol_out,
  output logic [STATUS_W-1:0]   out_status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  o2msg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  o2msg_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (in_opcode),
    .in_symbol_a     (in_symbol_a),
    .in_symbol_b     (in_symbol_b),
    .in_random_value (in_random_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol_out  (out_symbol_out),
    .out_status      (out_status)
  );

endmodule

// File: verif/tb_order2_markov_symbol_generator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for order2_markov_symbol_generator_unit: a scoreboard class
// predicts every response of the unit, and plain tasks drive requests and registers.
// Depends on o2msg_pkg and the unit's RTL.
module tb_order2_markov_symbol_generator_unit;
  import o2msg_pkg::*;

  localparam int MAX_SYMBOLS = 32;
  localparam int COUNT_W = 16;
  localparam int TABLE_DEPTH = MAX_SYMBOLS * MAX_SYMBOLS * MAX_SYMBOLS;
  localparam int DIRECTED_ITEMS = 28;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SYM_IN_W-1:0] symbol;
    status_t             status;
  } symbol_result_t;

  class chain_scoreboard;
    bit [COUNT_W-1:0]   counts [TABLE_DEPTH];
    bit [SYM_IN_W-1:0]  learn_old, learn_new, walk_old, walk_new;
    bit [SYM_IN_W-1:0]  seed_first, seed_second;
    bit [PHASE_W-1:0]   seed_phase;
    bit [ALPHA_W-1:0]   alpha;
    symbol_result_t     due_results[$];
    int unsigned        failures;

    function new();
      alpha = ALPHA_RESET;
      seed_phase = PHASE_FIRST;
      failures = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_ALPHA:       alpha = value;
        CFG_INIT_FIRST:  seed_first = value[SYM_IN_W-1:0];
        CFG_INIT_SECOND: seed_second = value[SYM_IN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_n();
      if (alpha == 0) return 1;
      if (alpha > MAX_SYMBOLS) return MAX_SYMBOLS;
      return int'(alpha);
    endfunction

    function int unsigned row_base(int unsigned older, int unsigned newer);
      return (older * MAX_SYMBOLS + newer) * MAX_SYMBOLS;
    endfunction

    function int unsigned row_total();
      int unsigned n;
      n = active_n();
      if (walk_old >= n || walk_new >= n) return 0;
      return int'(counts[row_base(walk_old, walk_new) + n - 1]);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SYM_IN_W-1:0] a,
                               logic [SYM_IN_W-1:0] b, logic [RAND_W-1:0] r);
      int unsigned n, base, idx, j;
      symbol_result_t res;
      n = active_n();
      res.symbol = '0;
      res.status = STAT_OK;
      case (op)
        OP_CLEAR: begin
          foreach (counts[i]) counts[i] = '0;
        end
        OP_SET_CTX: begin
          if (a >= n || b >= n) res.status = STAT_RANGE;
          else begin
            learn_old = a;
            learn_new = b;
          end
        end
        OP_LEARN: begin
          if (a >= n || learn_old >= n || learn_new >= n) res.status = STAT_RANGE;
          else begin
            idx = row_base(learn_old, learn_new) + a;
            counts[idx] = counts[idx] + 16'd1;
            learn_old = learn_new;
            learn_new = a;
          end
        end
        OP_FINALIZE: begin
          for (int unsigned i = 0; i < n; i++) begin
            for (int unsigned k = 0; k < n; k++) begin
              base = row_base(i, k);
              for (int unsigned m = 1; m < n; m++)
                counts[base + m] = counts[base + m] + counts[base + m - 1];
            end
          end
        end
        OP_GENERATE: begin
          if (seed_phase == PHASE_FIRST) begin
            res.symbol = walk_old;
            seed_phase = PHASE_SECOND;
          end else if (seed_phase == PHASE_SECOND) begin
            res.symbol = walk_new;
            seed_phase = PHASE_DONE;
          end else if (walk_old >= n || walk_new >= n) begin
            res.status = STAT_RANGE;
          end else begin
            base = row_base(walk_old, walk_new);
            if (counts[base + n - 1] == 0) res.status = STAT_DEAD;
            else begin
              // Highest index whose preceding running sum does not exceed the draw, else zero.
              j = n - 1;
              while (j > 0 && counts[base + j - 1] > r) j--;
              res.symbol = SYM_IN_W'(j);
              walk_old = walk_new;
              walk_new = SYM_IN_W'(j);
            end
          end
        end
        OP_RESTART: begin
          walk_old = seed_first;
          walk_new = seed_second;
          seed_phase = PHASE_FIRST;
        end
        default: ;
      endcase
      due_results.push_back(res);
    endfunction

    function void check_result(logic [SYM_IN_W-1:0] sym, logic [STATUS_W-1:0] status);
      symbol_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: response with no request waiting, symbol_out %0d, status %0d",
                 $time, sym, status);
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (sym !== want.symbol) begin
        $display("%0t: symbol_out mismatch, expected %0d, actual %0d",
                 $time, want.symbol, sym);
        failures++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [SYM_IN_W-1:0]   in_symbol_a = '0;
  logic [SYM_IN_W-1:0]   in_symbol_b = '0;
  logic [RAND_W-1:0]     in_random_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SYM_IN_W-1:0]   out_symbol_out;
  logic [STATUS_W-1:0]   out_status;

  chain_scoreboard sb;
  int unsigned     items_sent = 0;
  int unsigned     burst_left = 0;
  int unsigned     stall_cycles = 0;
  int unsigned     stall_mode = 0;
  int unsigned     mode_timer = 0;
  longint          cycle_count = 0;

  order2_markov_symbol_generator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_symbol_a     (in_symbol_a),
    .in_symbol_b     (in_symbol_b),
    .in_random_value (in_random_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol_out  (out_symbol_out),
    .out_status      (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_symbol_out, out_status);
  end

  // The receiver switches at random among three stall habits: none, short stalls and long stalls.
  always @(negedge clk) begin
    if (stall_cycles != 0) begin
      out_ready <= 1'b0;
      stall_cycles--;
    end else begin
      out_ready <= 1'b1;
      if (stall_mode == 1 && $urandom_range(0, 2) == 0) stall_cycles = $urandom_range(1, 3);
      if (stall_mode == 2 && $urandom_range(0, 7) == 0) stall_cycles = $urandom_range(4, 16);
    end
    mode_timer++;
    if (mode_timer == 300) begin
      mode_timer = 0;
      stall_mode = $urandom_range(0, 2);
    end
  end

  function automatic logic [SYM_IN_W-1:0] any_symbol();
    return SYM_IN_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [SYM_IN_W-1:0] pick_symbol(int unsigned n);
    return SYM_IN_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [RAND_W-1:0] any_word();
    return RAND_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [RAND_W-1:0] pick_draw();
    int unsigned total;
    total = sb.row_total();
    if (total != 0 && $urandom_range(0, 7) != 0) return RAND_W'($urandom_range(0, total - 1));
    return any_word();
  endfunction

  task automatic issue(input logic [OP_W-1:0] op, input logic [SYM_IN_W-1:0] a,
                       input logic [SYM_IN_W-1:0] b, input logic [RAND_W-1:0] r);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_symbol_a <= a;
    in_symbol_b <= b;
    in_random_value <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, a, b, r);
    items_sent++;
    if (burst_left != 0) burst_left--;
    else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic issue_noise(input int unsigned n);
    logic [OP_W-1:0] op;
    op = OP_W'($urandom_range(0, 7));
    if (op == OP_CLEAR) op = OP_RESTART;
    if (op == OP_FINALIZE && n > 8) op = OP_GENERATE;
    issue(op, any_symbol(), any_symbol(), any_word());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic run_phase(input int unsigned p);
    int unsigned n, learns, gens, fins;
    logic [CFG_DATA_W-1:0] alpha_w, seed_w;
    wait_drained();
    case (p % 10)
      3: alpha_w = 6'd32;
      7: alpha_w = 6'd63;
      5: alpha_w = 6'd0;
      9: alpha_w = CFG_DATA_W'($urandom_range(9, 16));
      default: alpha_w = CFG_DATA_W'($urandom_range(1, 8));
    endcase
    write_register(CFG_ALPHA, alpha_w);
    n = sb.active_n();
    seed_w = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 63))
                                         : CFG_DATA_W'($urandom_range(0, n - 1));
    write_register(CFG_INIT_FIRST, seed_w);
    seed_w = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 63))
                                         : CFG_DATA_W'($urandom_range(0, n - 1));
    write_register(CFG_INIT_SECOND, seed_w);
    if ($urandom_range(0, 2) == 0) issue(OP_CLEAR, any_symbol(), any_symbol(), any_word());
    issue(OP_SET_CTX, pick_symbol(n), pick_symbol(n), any_word());
    learns = $urandom_range(8, 40);
    repeat (learns) begin
      if ($urandom_range(0, 9) == 0) issue_noise(n);
      else issue(OP_LEARN, pick_symbol(n), any_symbol(), any_word());
    end
    // Many passes over a small table push the running sums past the count width.
    if (n > 16) fins = 1;
    else if (n <= 8 && $urandom_range(0, 3) == 0) fins = 14;
    else fins = $urandom_range(0, 2);
    repeat (fins) issue(OP_FINALIZE, any_symbol(), any_symbol(), any_word());
    issue(OP_RESTART, any_symbol(), any_symbol(), any_word());
    gens = $urandom_range(10, 40);
    repeat (gens) begin
      if ($urandom_range(0, 9) == 0) issue_noise(n);
      else issue(OP_GENERATE, any_symbol(), any_symbol(), pick_draw());
    end
  endtask

  initial begin
    int unsigned p;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    write_register(CFG_ALPHA, 6'd4);
    write_register(CFG_INIT_FIRST, 6'd1);
    write_register(CFG_INIT_SECOND, 6'd2);
    issue(OP_SPARE_HI, 5'd31, 5'd31, 16'hFFFF);
    issue(OP_SPARE_LO, 5'd0, 5'd0, 16'h0000);
    issue(OP_CLEAR, 5'd31, 5'd0, 16'h0000);
    issue(OP_SET_CTX, 5'd5, 5'd0, 16'h0000);
    issue(OP_SET_CTX, 5'd0, 5'd31, 16'h0000);
    issue(OP_SET_CTX, 5'd1, 5'd2, 16'h0000);
    issue(OP_LEARN, 5'd3, 5'd0, 16'h0000);
    issue(OP_LEARN, 5'd31, 5'd0, 16'h0000);
    issue(OP_SET_CTX, 5'd1, 5'd2, 16'h0000);
    issue(OP_LEARN, 5'd0, 5'd0, 16'h0000);
    issue(OP_SET_CTX, 5'd1, 5'd2, 16'h0000);
    issue(OP_LEARN, 5'd2, 5'd0, 16'h0000);
    issue(OP_FINALIZE, 5'd0, 5'd0, 16'h0000);
    issue(OP_FINALIZE, 5'd0, 5'd0, 16'h0000);
    issue(OP_RESTART, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'hFFFF);
    issue(OP_RESTART, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd31, 5'd31, 16'hFFFF);

    wait_drained();
    write_register(CFG_ALPHA, 6'd0);
    write_register(CFG_INIT_FIRST, 6'd63);
    write_register(CFG_INIT_SECOND, 6'd0);
    issue(OP_SET_CTX, 5'd0, 5'd1, 16'h0000);
    issue(OP_RESTART, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);
    issue(OP_GENERATE, 5'd0, 5'd0, 16'h0000);

    p = 0;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      run_phase(p);
      p++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
